FILE: rtl/stma_pkg.sv
// Package for the sparse triplet matrix adder.
// Holds the payload structs, action and result status codes, register indexes,
// the controller state type and the controller/datapath command and status structs.
package stma_pkg;

  // Input item
  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         entry_row;
    logic [7:0]         entry_col;
    logic signed [31:0] entry_value;
  } stma_in_t;

  // Result item
  typedef struct packed {
    logic [7:0]         sum_row;
    logic [7:0]         sum_col;
    logic signed [31:0] sum_value;
    logic [1:0]         status;
    logic               last;
  } stma_out_t;

  // Action codes
  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_RUN         = 2'd2;

  // Result status codes
  localparam logic [1:0] RES_VALID    = 2'd0;
  localparam logic [1:0] RES_MISMATCH = 2'd1;
  localparam logic [1:0] RES_EMPTY    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned DIM_BITS       = 9;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_ROWS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_COLS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_ROWS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_COLS = 3'd3;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_MERGE
  } stma_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic emit_mismatch;
    logic emit_empty;
    logic emit_entry;
    logic clear;
  } stma_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mismatch;
    logic empty;
    logic last_entry;
  } stma_stat_t;

endpackage

FILE: rtl/stma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stma_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stma_ctrl.sv
// Controller for the sparse triplet matrix adder: decodes items and sequences the merge.
// Depends on stma_pkg.
module stma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          action,
  input  stma_pkg::stma_stat_t stat,
  output stma_pkg::stma_cmd_t  cmd,
  output logic                busy
);
  import stma_pkg::*;

  stma_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_LOAD_FIRST:  cmd.load_first  = 1'b1;
            ACT_LOAD_SECOND: cmd.load_second = 1'b1;
            ACT_RUN:         state_next      = S_MERGE;
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        busy = 1'b1;
        if (stat.mismatch) begin
          cmd.emit_mismatch = 1'b1;
          cmd.clear         = 1'b1;
          state_next        = S_IDLE;
        end else if (stat.empty) begin
          cmd.emit_empty = 1'b1;
          cmd.clear      = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.emit_entry = 1'b1;
          if (stat.last_entry) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/stma_dp.sv
// Datapath for the sparse triplet matrix adder: config registers, both entry lists,
// head pointers, key compare, adder and the result register.
// Depends on stma_pkg and stma_ram.
module stma_dp #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [stma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [stma_pkg::DIM_BITS-1:0]         cfg_data,
  input  stma_pkg::stma_in_t                    entry,
  input  stma_pkg::stma_cmd_t                   cmd,
  output stma_pkg::stma_stat_t                  stat,
  output logic                                  result_valid,
  output stma_pkg::stma_out_t                   result
);
  import stma_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = 16 + VALUE_BITS;

  // Config registers
  logic [DIM_BITS-1:0] first_rows, first_cols, second_rows, second_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_rows  <= DIM_BITS'(1);
      first_cols  <= DIM_BITS'(1);
      second_rows <= DIM_BITS'(1);
      second_cols <= DIM_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_ROWS:  first_rows  <= cfg_data;
        CFG_FIRST_COLS:  first_cols  <= cfg_data;
        CFG_SECOND_ROWS: second_rows <= cfg_data;
        CFG_SECOND_COLS: second_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fill counts and head pointers
  logic [CW-1:0] count_a, count_b, ptr_a, ptr_b, ptr_a_next, ptr_b_next;
  logic          we_a, we_b;
  logic [EW-1:0] wdata, rdata_a, rdata_b;

  assign we_a  = cmd.load_first  && (count_a < CW'(ENTRIES));
  assign we_b  = cmd.load_second && (count_b < CW'(ENTRIES));
  assign wdata = {entry.entry_row, entry.entry_col,
                  VALUE_BITS'($unsigned(entry.entry_value))};

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.clear) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (we_a) count_a <= count_a + CW'(1);
      if (we_b) count_b <= count_b + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_a <= '0;
      ptr_b <= '0;
    end else begin
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
    end
  end

  // Entry lists; read address follows the next head so data lines up with the pointer
  stma_ram #(.WIDTH(EW), .DEPTH(ENTRIES), .AW(AW)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (wdata),
    .raddr (ptr_a_next[AW-1:0]),
    .rdata (rdata_a)
  );

  stma_ram #(.WIDTH(EW), .DEPTH(ENTRIES), .AW(AW)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (wdata),
    .raddr (ptr_b_next[AW-1:0]),
    .rdata (rdata_b)
  );

  // Head compare and select
  logic                  a_live, b_live, take_a, take_b;
  logic [15:0]           key_a, key_b;
  logic [VALUE_BITS-1:0] val_a, val_b;
  logic [CW-1:0]         ptr_a_inc, ptr_b_inc;
  logic signed [VALUE_BITS-1:0] sum_v;
  logic [7:0]            sel_row, sel_col;

  assign a_live = ptr_a < count_a;
  assign b_live = ptr_b < count_b;
  assign key_a  = rdata_a[EW-1 -: 16];
  assign key_b  = rdata_b[EW-1 -: 16];
  assign val_a  = rdata_a[VALUE_BITS-1:0];
  assign val_b  = rdata_b[VALUE_BITS-1:0];
  assign take_a = a_live && (!b_live || key_a <= key_b);
  assign take_b = b_live && (!a_live || key_b <= key_a);

  assign sum_v   = (take_a ? val_a : '0) + (take_b ? val_b : '0);
  assign sel_row = take_a ? key_a[15:8] : key_b[15:8];
  assign sel_col = take_a ? key_a[7:0]  : key_b[7:0];

  assign ptr_a_inc = ptr_a + CW'(take_a);
  assign ptr_b_inc = ptr_b + CW'(take_b);

  always_comb begin
    if (cmd.clear) begin
      ptr_a_next = '0;
      ptr_b_next = '0;
    end else if (cmd.emit_entry) begin
      ptr_a_next = ptr_a_inc;
      ptr_b_next = ptr_b_inc;
    end else begin
      ptr_a_next = ptr_a;
      ptr_b_next = ptr_b;
    end
  end

  // Status to controller
  assign stat.mismatch   = (first_rows != second_rows) || (first_cols != second_cols);
  assign stat.empty      = (count_a == '0) && (count_b == '0);
  assign stat.last_entry = (ptr_a_inc >= count_a) && (ptr_b_inc >= count_b);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_entry || cmd.emit_mismatch || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_entry) begin
      result.sum_row   <= sel_row;
      result.sum_col   <= sel_col;
      result.sum_value <= 32'(sum_v);
      result.status    <= RES_VALID;
      result.last      <= stat.last_entry;
    end else if (cmd.emit_mismatch || cmd.emit_empty) begin
      result.sum_row   <= '0;
      result.sum_col   <= '0;
      result.sum_value <= '0;
      result.status    <= cmd.emit_mismatch ? RES_MISMATCH : RES_EMPTY;
      result.last      <= 1'b1;
    end
  end

endmodule

FILE: rtl/sparse_triplet_matrix_add.sv
// Sparse triplet matrix adder. During a load busy stays low.
// A run holds busy until its final result is chosen (one result when dimensions differ or
// both lists are empty); results are registered and stream one per cycle, paced by the head
// compare on the registered list read ports.
// Reset: dimensions to 1, both fill counts to zero, list contents undefined until loaded.
// The receiver cannot stall; each result strobe lasts one cycle.
module sparse_triplet_matrix_add #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  stma_pkg::stma_in_t                  entry,
  output logic                                result_valid,
  output stma_pkg::stma_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stma_pkg::DIM_BITS-1:0]       cfg_data
);
  import stma_pkg::*;

  stma_cmd_t  cmd;
  stma_stat_t stat;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  stma_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (entry.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  stma_dp #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry        (entry),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

  // A run beat always starts a merge
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && entry.action == ACT_RUN |=> busy)
    else $error("run accepted but merge did not start");

  // Results only come out of a merge
  a_res_from_merge: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a merge cycle");

  // The final result ends the merge
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("merge still running after final result");

  // A result that is not final means more are coming
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("merge stopped before final result");

  // Mismatch and empty are single-beat runs
  a_special_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != RES_VALID |-> result.last)
    else $error("special status not marked final");

endmodule

FILE: tb/stma_sum_monitor.sv
// Result monitor for the sparse triplet matrix adder: tracks the dimension registers and
// both coordinate lists, works out the merged sums per run beat and compares every result.
// Depends on stma_pkg for the payload structs, action, status and register codes.
module stma_sum_monitor #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  stma_pkg::stma_in_t                  entry,
  input  logic                                result_valid,
  input  stma_pkg::stma_out_t                 result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [stma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stma_pkg::DIM_BITS-1:0]       cfg_data,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stma_pkg::*;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] val;
  } triplet_t;

  logic [DIM_BITS-1:0] a_rows, a_cols, b_rows, b_cols;
  triplet_t            a_list [ENTRIES];
  triplet_t            b_list [ENTRIES];
  int                  a_count, b_count;
  stma_out_t           expected_sums [$];
  int                  sums_seen;

  task automatic report(input string what);
    $display("ERROR @%0t result %0d: %s", $time, sums_seen, what);
    errors++;
  endtask

  task automatic push_sum(input logic [7:0] row, input logic [7:0] col,
                          input logic [31:0] val, input logic [1:0] status,
                          input logic last);
    stma_out_t s;
    s.sum_row   = row;
    s.sum_col   = col;
    s.sum_value = val;
    s.status    = status;
    s.last      = last;
    expected_sums.push_back(s);
  endtask

  // Row-major merge of both lists; equal positions add with 32-bit wrap
  task automatic merge_lists();
    int       ia, ib;
    triplet_t pick;
    ia = 0;
    ib = 0;
    if (a_rows != b_rows || a_cols != b_cols) begin
      push_sum('0, '0, '0, RES_MISMATCH, 1'b1);
    end else if (a_count == 0 && b_count == 0) begin
      push_sum('0, '0, '0, RES_EMPTY, 1'b1);
    end else begin
      while (ia < a_count || ib < b_count) begin
        if (ia < a_count && (ib >= b_count ||
            {a_list[ia].row, a_list[ia].col} < {b_list[ib].row, b_list[ib].col})) begin
          pick = a_list[ia];
          ia++;
        end else if (ia >= a_count ||
            {b_list[ib].row, b_list[ib].col} < {a_list[ia].row, a_list[ia].col}) begin
          pick = b_list[ib];
          ib++;
        end else begin
          pick     = a_list[ia];
          pick.val = a_list[ia].val + b_list[ib].val;
          ia++;
          ib++;
        end
        push_sum(pick.row, pick.col, pick.val, RES_VALID, ia >= a_count && ib >= b_count);
      end
    end
    a_count = 0;
    b_count = 0;
  endtask

  task automatic check_sum();
    stma_out_t want;
    if (expected_sums.size() == 0) begin
      report("result with nothing expected");
    end else begin
      want = expected_sums.pop_front();
      if (result.sum_row !== want.sum_row)
        report($sformatf("sum_row %0d, want %0d", result.sum_row, want.sum_row));
      if (result.sum_col !== want.sum_col)
        report($sformatf("sum_col %0d, want %0d", result.sum_col, want.sum_col));
      if (result.sum_value !== want.sum_value)
        report($sformatf("sum_value %h, want %h", result.sum_value, want.sum_value));
      if (result.status !== want.status)
        report($sformatf("status %0d, want %0d", result.status, want.status));
      if (result.last !== want.last)
        report($sformatf("last %b, want %b", result.last, want.last));
    end
    sums_seen++;
  endtask

  // Results first: a run's results never share an edge with its own beat
  always @(posedge clk) begin
    if (rst) begin
      a_rows    = 9'd1;
      a_cols    = 9'd1;
      b_rows    = 9'd1;
      b_cols    = 9'd1;
      a_count   = 0;
      b_count   = 0;
      errors    = 0;
      sums_seen = 0;
      expected_sums.delete();
    end else begin
      if (result_valid) check_sum();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_ROWS:  a_rows = cfg_data;
          CFG_FIRST_COLS:  a_cols = cfg_data;
          CFG_SECOND_ROWS: b_rows = cfg_data;
          CFG_SECOND_COLS: b_cols = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (entry.action)
          ACT_LOAD_FIRST: begin
            if (a_count < ENTRIES) begin
              a_list[a_count] = {entry.entry_row, entry.entry_col, entry.entry_value};
              a_count++;
            end
          end
          ACT_LOAD_SECOND: begin
            if (b_count < ENTRIES) begin
              b_list[b_count] = {entry.entry_row, entry.entry_col, entry.entry_value};
              b_count++;
            end
          end
          ACT_RUN: merge_lists();
          default: ;
        endcase
      end
    end
    pending = expected_sums.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the sparse triplet matrix adder bench: clock, reset, beats and register writes.
// Uses stma_pkg, the block sparse_triplet_matrix_add and the monitor stma_sum_monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stma_pkg::*;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS  = 120;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         CYCLE_LIMIT   = 200000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  stma_in_t                  entry;
  logic                      result_valid;
  stma_out_t                 result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]       cfg_data;
  int                        errors;
  int                        pending;
  int                        cycles = 0;
  int                        burst_left = 0;
  int                        random_items = 0;

  sparse_triplet_matrix_add dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .entry        (entry),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  stma_sum_monitor mon (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .entry        (entry),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sparse_triplet_matrix_add: FAILED **");
      $finish;
    end
  end

  function automatic stma_in_t make_item(input logic [1:0] act, input logic [15:0] key,
                                         input logic [31:0] val);
    stma_in_t item;
    item.action                        = act;
    {item.entry_row, item.entry_col}   = key;
    item.entry_value                   = val;
    return item;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(16, 18);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // One beat; bursts of random length with random gaps, start held across a burst
  task automatic send_item(input stma_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    entry <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_run();
    send_item(make_item(ACT_RUN, 16'($urandom()), $urandom()));
  endtask

  // Drain outstanding results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [DIM_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All four dimensions, optionally preceded by a write to an unused index
  task automatic set_dims(input logic [8:0] fr, input logic [8:0] fc, input logic [8:0] sr,
                          input logic [8:0] sc, input bit stray);
    if (stray) write_reg(CFG_SECOND_COLS + 3'($urandom_range(1, 4)), 9'($urandom()));
    write_reg(CFG_FIRST_ROWS, fr);
    write_reg(CFG_FIRST_COLS, fc);
    write_reg(CFG_SECOND_ROWS, sr);
    write_reg(CFG_SECOND_COLS, sc);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_dims();
    logic [8:0] r, c;
    bit         stray;
    r     = 9'($urandom_range(1, 256));
    c     = 9'($urandom_range(1, 256));
    stray = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 6))
      0:       set_dims(9'd256, 9'd256, 9'd256, 9'd256, stray);
      1:       set_dims(9'd1, 9'd1, 9'd1, 9'd1, stray);
      2:       set_dims(r, c, r ^ 9'(1 << $urandom_range(0, 8)), c, stray);
      3:       set_dims(r, c, r, c ^ 9'(1 << $urandom_range(0, 8)), stray);
      4:       set_dims(9'h1ff, 9'h000, 9'h1ff, 9'h000, stray);
      default: set_dims(r, c, r, c, stray);
    endcase
  endtask

  // Builds one position list; mostly ascending, sometimes shuffled with repeats
  task automatic build_list(input logic [1:0] act, input int n, input logic [15:0] base,
                            input bit broken, ref stma_in_t list [$]);
    logic [15:0] key;
    key = base;
    for (int i = 0; i < n; i++) begin
      if (broken)
        key = ($urandom_range(0, 3) == 0) ? key : 16'($urandom_range(base, base + 40));
      else
        key = key + 16'($urandom_range(1, 4));
      list.push_back(make_item(act, key, pick_value()));
    end
  endtask

  // Two lists sharing a base so positions collide, loads interleaved, then a run
  task automatic send_random_matrices();
    stma_in_t    la [$];
    stma_in_t    lb [$];
    logic [15:0] base;
    bit          broken;
    base   = 16'($urandom_range(0, 16'hffff - 80));
    broken = ($urandom_range(0, 7) == 0);
    build_list(ACT_LOAD_FIRST, pick_count(), base, broken, la);
    build_list(ACT_LOAD_SECOND, pick_count(), base, broken, lb);
    while (la.size() > 0 || lb.size() > 0) begin
      if ($urandom_range(0, 11) == 0)
        send_item(make_item(ACT_UNUSED, 16'($urandom()), $urandom()));
      if (lb.size() == 0 || (la.size() > 0 && $urandom_range(0, 1) == 1))
        send_item(la.pop_front());
      else
        send_item(lb.pop_front());
      random_items++;
    end
    send_run();
    random_items++;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    entry     = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset dimensions; empty lists first
    send_run();
    // Wrap at the positive extreme; an unordered tail in the second list keeps the 0707 pair apart
    send_item(make_item(ACT_LOAD_FIRST, 16'h0000, 32'h7fff_ffff));
    send_item(make_item(ACT_LOAD_SECOND, 16'h0000, 32'h0000_0001));
    send_item(make_item(ACT_LOAD_FIRST, 16'h0005, 32'h8000_0000));
    send_item(make_item(ACT_LOAD_SECOND, 16'h0003, 32'hffff_ffff));
    send_item(make_item(ACT_LOAD_SECOND, 16'hffff, 32'h8000_0000));
    send_item(make_item(ACT_LOAD_FIRST, 16'h0707, 32'd10));
    send_item(make_item(ACT_LOAD_SECOND, 16'h0707, -32'sd10));
    send_item(make_item(ACT_UNUSED, 16'hffff, 32'hffff_ffff));
    send_run();
    // Full second list: the seventeenth load is dropped
    for (int i = 0; i < 17; i++)
      send_item(make_item(ACT_LOAD_SECOND, {8'(i * 15), 8'(255 - i)}, pick_value()));
    send_run();

    // Column mismatch, with a pending load that the run must clear
    wait_idle();
    set_dims(9'd256, 9'd256, 9'd256, 9'd1, 1'b1);
    send_item(make_item(ACT_LOAD_FIRST, 16'h1234, 32'h0000_0042));
    send_run();
    wait_idle();
    set_dims(9'd256, 9'd256, 9'd256, 9'd256, 1'b0);
    send_run();

    // Random phases, each with its own dimension setting
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      pick_dims();
      repeat (3) send_random_matrices();
    end

    wait_idle();
    if (errors == 0) begin
      $display("** sparse_triplet_matrix_add: PASSED **");
    end else begin
      $display("** sparse_triplet_matrix_add: FAILED **");
    end
    $finish;
  end

endmodule
